// File: design/psrt_pkg.sv
// Shared types, constants and tables for the point scale/rotate/translate block.
`default_nettype none

package psrt_pkg;

	localparam int CORDIC_STEPS_DEFAULT = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W = 5;

	localparam int COORD_W = 32;
	localparam int SCALE_W = 16;
	localparam int ANGLE_W = 16;
	localparam int TRIG_W = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int HALF_TURN_Q6 = 11520;
	localparam int QUARTER_TURN_Q6 = 5760;
	localparam int FULL_TURN_Q6 = 23040;
	localparam int DEG_Q6_TO_RAD_Q30 = 292818;
	localparam int CORDIC_INV_GAIN = 32'h26DD3B6A;
	localparam int TRIG_ONE = 65536;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE   = 3'd0,
		REG_SCALE_X  = 3'd1,
		REG_SCALE_Y  = 3'd2,
		REG_ROTATION = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5
	} reg_index_e;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] world_x;
		logic signed [COORD_W-1:0] world_y;
		logic                      saturated;
	} point_out_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cosine;
		logic signed [TRIG_W-1:0] sine;
	} trig_t;

	function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: design/point_scale_rotate_translate.sv
// Top level: 2D point scale, rotate and translate with a shared multiplier.
// Each item is one vertex in Q16.16. With the transform enabled an item runs
// through ten products on one 33x18 signed multiplier (two scale products, then
// each rotated coordinate built from high and low halves of the scaled value),
// plus an accumulate drain, a saturating offset add and a result hand-off, and
// no new item is taken until the result is handed off. The first enabled item
// after reset or after any register write first runs the CORDIC (setup, then
// CORDIC_STEPS iterations, at most 24, then finish) and caches cosine and sine.
// With the transform disabled an item passes through unchanged. A new item is
// accepted while the previous result still waits in the output register.
// Register writes are taken at any time but are meant for an idle block.
`default_nettype none

module point_scale_rotate_translate #(
	parameter int CORDIC_STEPS = psrt_pkg::CORDIC_STEPS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  psrt_pkg::point_in_t                    in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output psrt_pkg::point_out_t                   out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [psrt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [psrt_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int CW = psrt_pkg::COORD_W;
	localparam int SW = psrt_pkg::SCALE_W;
	localparam int TW = psrt_pkg::TRIG_W;
	localparam int SX_W = CW + SW - 8;
	localparam int MA_W = 33;
	localparam int MB_W = TW;
	localparam int MP_W = MA_W + MB_W;
	localparam int ACC_W = 58;
	localparam int SUM_W = ACC_W - 16 + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRIG,
		S_MUL,
		S_DRAIN,
		S_SUM,
		S_FIN
	} state_t;

	typedef enum logic [3:0] {
		ST_SX,
		ST_SY,
		ST_SXC_HI,
		ST_SXC_LO,
		ST_SYS_HI,
		ST_SYS_LO,
		ST_SXS_HI,
		ST_SXS_LO,
		ST_SYC_HI,
		ST_SYC_LO
	} step_t;

	state_t                     state_q;
	step_t                      step_q;
	step_t                      rstep_q;
	logic                       rvalid_q;
	logic                       out_valid_q;
	psrt_pkg::point_out_t       out_q;
	psrt_pkg::point_out_t       res_q;

	logic                       enable_q;
	logic signed [SW-1:0]       scale_x_q;
	logic signed [SW-1:0]       scale_y_q;
	logic signed [SW-1:0]       rotation_q;
	logic signed [CW-1:0]       offset_x_q;
	logic signed [CW-1:0]       offset_y_q;
	logic signed [TW-1:0]       cos_q;
	logic signed [TW-1:0]       sin_q;
	logic                       trig_valid_q;

	logic signed [CW-1:0]       px_q;
	logic signed [CW-1:0]       py_q;
	logic signed [SX_W-1:0]     sx_q;
	logic signed [SX_W-1:0]     sy_q;
	logic signed [MP_W-1:0]     prod_q;
	logic signed [ACC_W-1:0]    acc_x_q;
	logic signed [ACC_W-1:0]    acc_y_q;

	logic                       in_accept;
	logic                       out_load;
	logic                       cfg_we;
	logic                       cfg_known;
	logic                       trig_start;
	logic                       trig_done;
	psrt_pkg::trig_t            trig;
	logic signed [MA_W-1:0]     mul_a;
	logic signed [MB_W-1:0]     mul_b;
	logic signed [MP_W-1:0]     mul_p;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    hi_term;
	logic signed [SUM_W-1:0]    sum_x;
	logic signed [SUM_W-1:0]    sum_y;
	logic [CW:0]                sat_x;
	logic [CW:0]                sat_y;

	function automatic logic [CW:0] sat_word(input logic signed [SUM_W-1:0] v);
		logic [CW:0] r;
		if (v[SUM_W-1:CW-1] == '0 || v[SUM_W-1:CW-1] == '1) begin
			r = {1'b0, v[CW-1:0]};
		end else if (v[SUM_W-1]) begin
			r = {1'b1, 1'b1, {(CW-1){1'b0}}};
		end else begin
			r = {1'b1, 1'b0, {(CW-1){1'b1}}};
		end
		return r;
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;
	assign trig_start = in_accept && enable_q && !trig_valid_q;

	always_comb begin
		case (cfg_index)
			psrt_pkg::REG_ENABLE,
			psrt_pkg::REG_SCALE_X,
			psrt_pkg::REG_SCALE_Y,
			psrt_pkg::REG_ROTATION,
			psrt_pkg::REG_OFFSET_X,
			psrt_pkg::REG_OFFSET_Y: cfg_known = 1'b1;
			default: cfg_known = 1'b0;
		endcase
	end

	psrt_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (trig_start),
		.angle (rotation_q),
		.done  (trig_done),
		.trig  (trig)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			scale_x_q <= psrt_pkg::SCALE_RESET;
			scale_y_q <= psrt_pkg::SCALE_RESET;
			rotation_q <= '0;
			offset_x_q <= '0;
			offset_y_q <= '0;
			cos_q <= '0;
			sin_q <= '0;
			trig_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					psrt_pkg::REG_ENABLE:   enable_q <= cfg_data[0];
					psrt_pkg::REG_SCALE_X:  scale_x_q <= cfg_data[SW-1:0];
					psrt_pkg::REG_SCALE_Y:  scale_y_q <= cfg_data[SW-1:0];
					psrt_pkg::REG_ROTATION: rotation_q <= cfg_data[SW-1:0];
					psrt_pkg::REG_OFFSET_X: offset_x_q <= cfg_data[CW-1:0];
					psrt_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data[CW-1:0];
					default: ;
				endcase
			end
			if (cfg_we && cfg_known) begin
				trig_valid_q <= 1'b0;
			end else if (trig_done) begin
				cos_q <= trig.cosine;
				sin_q <= trig.sine;
				trig_valid_q <= 1'b1;
			end
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			ST_SX: begin
				mul_a = MA_W'(px_q);
				mul_b = MB_W'(scale_x_q);
			end
			ST_SY: begin
				mul_a = MA_W'(py_q);
				mul_b = MB_W'(scale_y_q);
			end
			ST_SXC_HI: begin
				mul_a = MA_W'(signed'(sx_q[SX_W-1:16]));
				mul_b = cos_q;
			end
			ST_SXC_LO: begin
				mul_a = MA_W'(sx_q[15:0]);
				mul_b = cos_q;
			end
			ST_SYS_HI: begin
				mul_a = MA_W'(signed'(sy_q[SX_W-1:16]));
				mul_b = sin_q;
			end
			ST_SYS_LO: begin
				mul_a = MA_W'(sy_q[15:0]);
				mul_b = sin_q;
			end
			ST_SXS_HI: begin
				mul_a = MA_W'(signed'(sx_q[SX_W-1:16]));
				mul_b = sin_q;
			end
			ST_SXS_LO: begin
				mul_a = MA_W'(sx_q[15:0]);
				mul_b = sin_q;
			end
			ST_SYC_HI: begin
				mul_a = MA_W'(signed'(sy_q[SX_W-1:16]));
				mul_b = cos_q;
			end
			ST_SYC_LO: begin
				mul_a = MA_W'(sy_q[15:0]);
				mul_b = cos_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign prod_ext = ACC_W'(prod_q);
	assign hi_term = prod_ext <<< 16;
	assign sum_x = SUM_W'(signed'(acc_x_q[ACC_W-1:16])) + SUM_W'(offset_x_q);
	assign sum_y = SUM_W'(signed'(acc_y_q[ACC_W-1:16])) + SUM_W'(offset_y_q);
	assign sat_x = sat_word(sum_x);
	assign sat_y = sat_word(sum_y);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_q <= in_data.point_x;
			py_q <= in_data.point_y;
			if (!enable_q) begin
				res_q.world_x <= in_data.point_x;
				res_q.world_y <= in_data.point_y;
				res_q.saturated <= 1'b0;
			end
		end
		prod_q <= mul_p;
		rstep_q <= step_q;
		if (rvalid_q) begin
			case (rstep_q)
				ST_SX:     sx_q <= prod_q[SX_W+7:8];
				ST_SY:     sy_q <= prod_q[SX_W+7:8];
				ST_SXC_HI: acc_x_q <= hi_term;
				ST_SXC_LO: acc_x_q <= acc_x_q + prod_ext;
				ST_SYS_HI: acc_x_q <= acc_x_q - hi_term;
				ST_SYS_LO: acc_x_q <= acc_x_q - prod_ext;
				ST_SXS_HI: acc_y_q <= hi_term;
				ST_SXS_LO: acc_y_q <= acc_y_q + prod_ext;
				ST_SYC_HI: acc_y_q <= acc_y_q + hi_term;
				ST_SYC_LO: acc_y_q <= acc_y_q + prod_ext;
				default: ;
			endcase
		end
		if (state_q == S_SUM) begin
			res_q.world_x <= sat_x[CW-1:0];
			res_q.world_y <= sat_y[CW-1:0];
			res_q.saturated <= sat_x[CW] | sat_y[CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= ST_SX;
			rvalid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_q <= (state_q == S_MUL);
			out_valid_q <= out_load || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					step_q <= ST_SX;
					if (in_valid) begin
						if (!enable_q) begin
							state_q <= S_FIN;
						end else if (trig_valid_q) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_TRIG;
						end
					end
				end
				S_TRIG: begin
					if (trig_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_t'(step_q + 1'b1);
					if (step_q == ST_SYC_LO) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						out_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

// File: design/psrt_cordic.sv
// Iterative CORDIC: reduces the angle, then produces cosine and sine in Q2.16.
`default_nettype none

module psrt_cordic #(
	parameter int CORDIC_STEPS = psrt_pkg::CORDIC_STEPS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [psrt_pkg::ANGLE_W-1:0] angle,
	output logic                                done,
	output psrt_pkg::trig_t                     trig
);

	localparam int STEPS = (CORDIC_STEPS > psrt_pkg::ATAN_ENTRIES) ?
		psrt_pkg::ATAN_ENTRIES : CORDIC_STEPS;
	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [IW-1:0] LAST = IW'(STEPS - 1);
	localparam int XW = 34;
	localparam int AW = psrt_pkg::ANGLE_W + 1;
	localparam int TW = psrt_pkg::TRIG_W;

	localparam logic signed [AW-1:0] HALF_A = AW'(psrt_pkg::HALF_TURN_Q6);
	localparam logic signed [AW-1:0] NEG_HALF_A = AW'(-psrt_pkg::HALF_TURN_Q6);
	localparam logic signed [AW-1:0] FULL_A = AW'(psrt_pkg::FULL_TURN_Q6);
	localparam logic signed [AW-1:0] QUARTER_A = AW'(psrt_pkg::QUARTER_TURN_Q6);
	localparam logic signed [AW-1:0] NEG_QUARTER_A = AW'(-psrt_pkg::QUARTER_TURN_Q6);
	localparam logic signed [XW-1:0] RAD_K = XW'(psrt_pkg::DEG_Q6_TO_RAD_Q30);
	localparam logic signed [XW-1:0] INV_GAIN = XW'(psrt_pkg::CORDIC_INV_GAIN);
	localparam logic signed [XW-1:0] UNIT_P = XW'(psrt_pkg::TRIG_ONE);
	localparam logic signed [XW-1:0] UNIT_N = XW'(-psrt_pkg::TRIG_ONE);

	typedef enum logic [1:0] {
		C_IDLE,
		C_SETUP,
		C_ITER,
		C_FINISH
	} cstate_t;

	cstate_t                state_q;
	logic                   done_q;
	psrt_pkg::trig_t        trig_q;
	logic [IW-1:0]          i_q;
	logic signed [AW-1:0]   af_q;
	logic                   flip_q;
	logic signed [XW-1:0]   x_q;
	logic signed [XW-1:0]   y_q;
	logic signed [XW-1:0]   z_q;

	logic signed [AW-1:0]   a_s;
	logic signed [AW-1:0]   a_w;
	logic signed [AW-1:0]   a_f;
	logic                   flip;
	logic signed [XW-1:0]   xs;
	logic signed [XW-1:0]   ys;
	logic signed [XW-1:0]   at;
	logic signed [TW-1:0]   c_fin;
	logic signed [TW-1:0]   s_fin;

	function automatic logic signed [TW-1:0] clamp_unit(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] f;
		logic signed [XW-1:0] r;
		f = v >>> 14;
		if (f > UNIT_P) begin
			r = UNIT_P;
		end else if (f < UNIT_N) begin
			r = UNIT_N;
		end else begin
			r = f;
		end
		return r[TW-1:0];
	endfunction

	always_comb begin
		a_s = AW'(angle);
		if (a_s > HALF_A) begin
			a_w = a_s - FULL_A;
		end else if (a_s <= NEG_HALF_A) begin
			a_w = a_s + FULL_A;
		end else begin
			a_w = a_s;
		end
		flip = 1'b0;
		if (a_w > QUARTER_A) begin
			a_f = a_w - HALF_A;
			flip = 1'b1;
		end else if (a_w < NEG_QUARTER_A) begin
			a_f = a_w + HALF_A;
			flip = 1'b1;
		end else begin
			a_f = a_w;
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = XW'(psrt_pkg::atan_q30(psrt_pkg::ATAN_IDX_W'(i_q)));
	assign c_fin = clamp_unit(x_q);
	assign s_fin = clamp_unit(y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= (state_q == C_FINISH);
			case (state_q)
				C_IDLE: begin
					if (start) begin
						af_q <= a_f;
						flip_q <= flip;
						state_q <= C_SETUP;
					end
				end
				C_SETUP: begin
					z_q <= XW'(af_q) * RAD_K;
					x_q <= INV_GAIN;
					y_q <= '0;
					i_q <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					if (!z_q[XW-1]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end
					if (i_q == LAST) begin
						state_q <= C_FINISH;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				C_FINISH: begin
					trig_q.cosine <= flip_q ? -c_fin : c_fin;
					trig_q.sine <= flip_q ? -s_fin : s_fin;
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign trig = trig_q;

endmodule

`default_nettype wire

// File: design/psrt_checker.sv
// Port-level checks for the point transform block, bound to the top level.
`default_nettype none

module psrt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input psrt_pkg::point_out_t            out_data
);

	localparam logic signed [psrt_pkg::COORD_W-1:0] MAX_C = 32'sh7FFF_FFFF;
	localparam logic signed [psrt_pkg::COORD_W-1:0] MIN_C = 32'sh8000_0000;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in progress");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in progress");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			(out_data.world_x == MAX_C || out_data.world_x == MIN_C ||
			 out_data.world_y == MAX_C || out_data.world_y == MIN_C))
		else $error("saturated flag without a clamped coordinate");

endmodule

bind point_scale_rotate_translate psrt_checker u_psrt_checker (.*);

`default_nettype wire
